### hw/rtl/fq_pkg.sv
// ----------------------------------------------------------------------------
// fq_pkg
// Shared command codes, status codes and control structs for the FIFO queue
// with match counting.
// ----------------------------------------------------------------------------
package fq_pkg;

    localparam int OPCODE_BITS = 3;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;

    localparam logic [OPCODE_BITS-1:0] OP_ENQ   = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_DEQ   = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_PEEK  = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_COUNT = 3'd4;
    localparam logic [OPCODE_BITS-1:0] OP_CHECK = 3'd5;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    // Command broadcast from the controller to the whole cell chain.
    typedef struct packed {
        logic load;
        logic shift;
        logic rotate;
    } chain_cmd_t;

    // Decoded control for one cell of the chain.
    typedef struct packed {
        logic load;
        logic shift;
        logic wrap;
    } cell_ctrl_t;

endpackage

### hw/rtl/fifo_queue_with_match_count_core.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_match_count_core
// FIFO queue of words held in a chain of cells, with match counting and a
// never-increasing check.
// ----------------------------------------------------------------------------
// The queue front always sits in cell 0 of a chain of DEPTH cells. Enqueue,
// dequeue, peek, clear and unused opcodes register their result at the edge
// that accepts the transaction. Count and the decreasing check rotate the
// occupied cells once through the chain while the front cell is compared, and
// register their result as the rotation ends; with too few entries to scan,
// the result is registered at the accepting edge. One transaction is in work
// at a time; a new one is accepted at the same edge that the previous result
// is taken.
module fifo_queue_with_match_count_core #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fq_pkg::OPCODE_BITS-1:0]    opcode,
    input  logic [fq_pkg::VALUE_BITS-1:0]     value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fq_pkg::VALUE_BITS-1:0]     data_out,
    output logic [$clog2(DEPTH+1)-1:0]        match_count,
    output logic                              is_decreasing,
    output logic [fq_pkg::STATUS_BITS-1:0]    status,
    output logic [$clog2(DEPTH+1)-1:0]        occupancy
);
    import fq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WORD_BITS-1:0] words [DEPTH];
    logic [WORD_BITS-1:0] load_word;
    chain_cmd_t           chain_cmd;
    logic [CNT_W-1:0]     fill;

    fq_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_out      (data_out),
        .match_count   (match_count),
        .is_decreasing (is_decreasing),
        .status        (status),
        .occupancy     (occupancy),
        .front_word    (words[0]),
        .second_word   (words[1]),
        .load_word     (load_word),
        .chain_cmd     (chain_cmd),
        .fill          (fill)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t           ctrl;
        logic [WORD_BITS-1:0] next_word;

        assign ctrl.load  = chain_cmd.load && (fill == CNT_W'(i));
        assign ctrl.shift = chain_cmd.shift;
        // While rotating, the last occupied cell takes the front word.
        assign ctrl.wrap  = chain_cmd.rotate ? (fill == CNT_W'(i + 1))
                                             : (i == DEPTH - 1);

        if (i < DEPTH - 1)
        begin : g_inner
            assign next_word = words[i + 1];
        end
        else
        begin : g_last
            assign next_word = words[0];
        end

        fq_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .load_word (load_word),
            .next_word (next_word),
            .wrap_word (words[0]),
            .word      (words[i])
        );
    end

endmodule

### hw/rtl/fq_cell.sv
// ----------------------------------------------------------------------------
// fq_cell
// One storage cell of the queue chain: loads a new word, takes its neighbor's
// word when the chain shifts, or takes the front word when the chain wraps.
// ----------------------------------------------------------------------------
module fq_cell #(
    parameter int WORD_BITS = 32
) (
    input  logic                  clk,
    input  fq_pkg::cell_ctrl_t    ctrl,
    input  logic [WORD_BITS-1:0]  load_word,
    input  logic [WORD_BITS-1:0]  next_word,
    input  logic [WORD_BITS-1:0]  wrap_word,
    output logic [WORD_BITS-1:0]  word
);
    import fq_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = load_word;
        end
        else if (ctrl.shift)
        begin
            word_next = ctrl.wrap ? wrap_word : next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### hw/rtl/fq_ctrl.sv
// ----------------------------------------------------------------------------
// fq_ctrl
// Command controller: handshakes, fill level, scan sequencing for the count
// and decreasing-check commands, and the registered result.
// ----------------------------------------------------------------------------
module fq_ctrl #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [fq_pkg::OPCODE_BITS-1:0]         opcode,
    input  logic [fq_pkg::VALUE_BITS-1:0]          value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [fq_pkg::VALUE_BITS-1:0]          data_out,
    output logic [$clog2(DEPTH+1)-1:0]             match_count,
    output logic                                   is_decreasing,
    output logic [fq_pkg::STATUS_BITS-1:0]         status,
    output logic [$clog2(DEPTH+1)-1:0]             occupancy,
    input  logic [WORD_BITS-1:0]                   front_word,
    input  logic [WORD_BITS-1:0]                   second_word,
    output logic [WORD_BITS-1:0]                   load_word,
    output fq_pkg::chain_cmd_t                     chain_cmd,
    output logic [$clog2(DEPTH+1)-1:0]             fill
);
    import fq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int EXT_W = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [CNT_W-1:0]        acc_reg, acc_next;
    logic                    decr_reg, decr_next;
    logic                    check_reg, check_next;
    logic [WORD_BITS-1:0]    key_reg, key_next;

    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]   data_reg;
    logic [CNT_W-1:0]        match_reg;
    logic                    decr_out_reg;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [CNT_W-1:0]        occ_reg;

    logic                    accept;
    logic                    res_load;
    logic [VALUE_BITS-1:0]   res_data;
    logic [CNT_W-1:0]        res_match;
    logic                    res_decr;
    logic [STATUS_BITS-1:0]  res_status;
    logic [EXT_W-1:0]        value_ext;
    logic [EXT_W-1:0]        front_ext;
    logic [WORD_BITS-1:0]    value_word;
    logic                    hit;
    logic                    rise;
    logic                    last_step;
    logic [CNT_W-1:0]        acc_sum;

    assign value_ext  = EXT_W'(value);
    assign value_word = value_ext[WORD_BITS-1:0];
    assign front_ext  = EXT_W'(front_word);

    // A pending result that is not taken holds off the next transaction.
    assign in_stall = (state_reg == ST_SCAN) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign hit       = (front_word == key_reg);
    assign rise      = (front_word < second_word);
    assign last_step = ((CNT_W'(step_reg) + CNT_W'(1)) == fill_reg);
    assign acc_sum   = acc_reg + CNT_W'(hit);

    always_comb
    begin
        chain_cmd  = '0;
        res_load   = 1'b0;
        res_data   = '0;
        res_match  = '0;
        res_decr   = 1'b0;
        res_status = STATUS_OK;
        state_next = state_reg;
        fill_next  = fill_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        decr_next  = decr_reg;
        check_next = check_reg;
        key_next   = key_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_ENQ:
                        begin
                            res_load = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                res_status = STATUS_FULL;
                            end
                            else
                            begin
                                chain_cmd.load = 1'b1;
                                fill_next      = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQ, OP_PEEK:
                        begin
                            res_load = 1'b1;
                            if (fill_reg == '0)
                            begin
                                res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                res_data = front_ext[VALUE_BITS-1:0];
                                if (opcode == OP_DEQ)
                                begin
                                    chain_cmd.shift = 1'b1;
                                    fill_next       = fill_reg - CNT_W'(1);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            res_load  = 1'b1;
                            fill_next = '0;
                        end
                        OP_COUNT:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                step_next  = '0;
                                acc_next   = '0;
                                decr_next  = 1'b1;
                                check_next = 1'b0;
                                key_next   = value_word;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (fill_reg < CNT_W'(2))
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                step_next  = '0;
                                acc_next   = '0;
                                decr_next  = 1'b1;
                                check_next = 1'b1;
                                key_next   = value_word;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // The occupied part of the chain rotates once; at the end of the scan
                // every entry is back in its original cell.
                chain_cmd.shift  = 1'b1;
                chain_cmd.rotate = 1'b1;
                if (!check_reg)
                begin
                    acc_next = acc_sum;
                end
                else if (!last_step && rise)
                begin
                    decr_next = 1'b0;
                end
                if (last_step)
                begin
                    state_next = ST_IDLE;
                    res_load   = 1'b1;
                    res_match  = check_reg ? '0 : acc_sum;
                    res_decr   = check_reg && decr_reg;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        decr_reg  <= decr_next;
        check_reg <= check_next;
        key_reg   <= key_next;
        if (res_load)
        begin
            data_reg     <= res_data;
            match_reg    <= res_match;
            decr_out_reg <= res_decr;
            status_reg   <= res_status;
            occ_reg      <= fill_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_out      = data_reg;
    assign match_count   = match_reg;
    assign is_decreasing = decr_out_reg;
    assign status        = status_reg;
    assign occupancy     = occ_reg;
    assign load_word     = value_word;
    assign fill          = fill_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill level exceeds queue depth");

    a_scan_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (fill_reg == $past(fill_reg)))
        else $error("fill level changed during a scan");

    a_scan_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(step_reg) < fill_reg))
        else $error("scan step ran past the occupied cells");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !res_load)
        else $error("result overwritten while stalled");
`endif

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the FIFO queue with match counting.
// A queue of commands feeds a bursty driver. A predictor tracks the queue
// contents and computes the result of each accepted command. A monitor
// compares every result field with the oldest prediction. The receiver
// stalls in changing patterns, with long hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int NUM_ITEMS  = 1550;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    // Opcodes with no function; the block treats them as no-ops.
    localparam logic [OPCODE_BITS-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_BITS-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] op;
        logic [VALUE_BITS-1:0]  word;
    } queue_cmd_t;

    typedef struct {
        logic [VALUE_BITS-1:0]  data;
        logic [CNT_BITS-1:0]    hits;
        logic                   decreasing;
        logic [STATUS_BITS-1:0] stat;
        logic [CNT_BITS-1:0]    fill;
    } queue_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [OPCODE_BITS-1:0] opcode = '0;
    logic [VALUE_BITS-1:0]  value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [VALUE_BITS-1:0]  data_out;
    logic [CNT_BITS-1:0]    match_count;
    logic                   is_decreasing;
    logic [STATUS_BITS-1:0] status;
    logic [CNT_BITS-1:0]    occupancy;

    queue_cmd_t             pending_cmds[$];
    queue_result_t          expected_results[$];
    logic [VALUE_BITS-1:0]  held_words[$];
    queue_cmd_t             next_cmd;

    int error_count = 0;
    int results_taken = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int pattern_phase = 0;
    int hold_left = 0;
    int holds_done = 0;
    int idle_cycles = 0;

    fifo_queue_with_match_count_core #(
        .DEPTH     (DEPTH),
        .WORD_BITS (VALUE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_out      (data_out),
        .match_count   (match_count),
        .is_decreasing (is_decreasing),
        .status        (status),
        .occupancy     (occupancy)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Updates the tracked queue contents and returns the result of one command.
    function automatic queue_result_t apply_command(logic [OPCODE_BITS-1:0] op,
                                                    logic [VALUE_BITS-1:0] word);
        queue_result_t r;
        r.data = '0;
        r.hits = '0;
        r.decreasing = 1'b0;
        r.stat = STATUS_OK;
        case (op)
            OP_ENQ:
            begin
                if (held_words.size() >= DEPTH)
                    r.stat = STATUS_FULL;
                else
                    held_words.push_back(word);
            end
            OP_DEQ, OP_PEEK:
            begin
                if (held_words.size() == 0)
                    r.stat = STATUS_EMPTY;
                else if (op == OP_DEQ)
                    r.data = held_words.pop_front();
                else
                    r.data = held_words[0];
            end
            OP_CLEAR:
                held_words.delete();
            OP_COUNT:
            begin
                foreach (held_words[i])
                    if (held_words[i] == word)
                        r.hits = r.hits + 1'b1;
            end
            OP_CHECK:
            begin
                if (held_words.size() >= 2)
                begin
                    r.decreasing = 1'b1;
                    for (int i = 1; i < held_words.size(); i++)
                        if (held_words[i-1] < held_words[i])
                            r.decreasing = 1'b0;
                end
            end
            default:
                ;
        endcase
        r.fill = CNT_BITS'(held_words.size());
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_word();
        logic [VALUE_BITS-1:0] w;
        case ($urandom_range(0, 4))
            0: w = '1;
            1: w = {1'b1, {(VALUE_BITS-1){1'b0}}};
            2: w = VALUE_BITS'($urandom_range(0, 3));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic add_cmd(logic [OPCODE_BITS-1:0] op, logic [VALUE_BITS-1:0] word);
        queue_cmd_t c;
        c.op = op;
        c.word = word;
        pending_cmds.push_back(c);
    endtask

    task automatic report_field(string name, logic [VALUE_BITS-1:0] exp_val,
                                logic [VALUE_BITS-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= '0;
            value <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(apply_command(opcode, value));
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_cmd.op;
                    value <= next_cmd.word;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 4) == 0)
                            gap_left = $urandom_range(5, 25);
                        else
                            gap_left = $urandom_range(1, 4);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall mode is redrawn whenever its random run length expires, and twice
    // the receiver holds off long enough for the block to refuse new input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
            pattern_phase = 0;
            hold_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left = mode_left - 1;
            pattern_phase = (pattern_phase + 1) % 7;
            if (hold_left == 0 && holds_done < 2 && results_taken >= 400 * (holds_done + 1))
            begin
                hold_left = HOLD_CYCLES;
                holds_done = holds_done + 1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= (pattern_phase < 3);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_taken <= results_taken + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual data %0h status %0d",
                         $time, data_out, status);
                error_count++;
            end
            else
            begin
                queue_result_t e;
                e = expected_results.pop_front();
                report_field("data_out", e.data, data_out);
                report_field("match_count", VALUE_BITS'(e.hits), VALUE_BITS'(match_count));
                report_field("is_decreasing", VALUE_BITS'(e.decreasing),
                             VALUE_BITS'(is_decreasing));
                report_field("status", VALUE_BITS'(e.stat), VALUE_BITS'(status));
                report_field("occupancy", VALUE_BITS'(e.fill), VALUE_BITS'(occupancy));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int step;
        logic [VALUE_BITS-1:0] w;

        // Empty queue corner cases.
        add_cmd(OP_DEQ, '0);
        add_cmd(OP_PEEK, '0);
        add_cmd(OP_COUNT, '0);
        add_cmd(OP_CHECK, '0);
        // One entry, equal neighbors, then a rise that breaks the order.
        add_cmd(OP_ENQ, '1);
        add_cmd(OP_CHECK, '0);
        add_cmd(OP_ENQ, '1);
        add_cmd(OP_CHECK, '0);
        add_cmd(OP_ENQ, '0);
        add_cmd(OP_CHECK, '0);
        add_cmd(OP_ENQ, 32'h1);
        add_cmd(OP_CHECK, '0);
        add_cmd(OP_COUNT, '1);
        add_cmd(OP_COUNT, '0);
        add_cmd(OP_PEEK, '0);
        add_cmd(OP_DEQ, '0);
        add_cmd(OP_SPARE_6, '1);
        add_cmd(OP_SPARE_7, 32'h5A5A_A5A5);
        add_cmd(OP_CLEAR, '0);
        add_cmd(OP_CLEAR, '1);

        while (pending_cmds.size() < NUM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = $urandom_range(1, DEPTH + 2);
                    repeat (n) add_cmd(OP_ENQ, pick_word());
                    add_cmd(OP_COUNT, pick_word());
                    add_cmd(OP_CHECK, $urandom);
                end
                2:
                begin
                    // Non-increasing run, sometimes all equal, sometimes with rises.
                    add_cmd(OP_CLEAR, $urandom);
                    n = $urandom_range(0, DEPTH + 1);
                    w = ($urandom_range(0, 1) == 0) ? '1 : $urandom;
                    step = $urandom_range(0, 2);
                    repeat (n)
                    begin
                        add_cmd(OP_ENQ, w);
                        if ($urandom_range(0, 9) == 0)
                            w = w + 1'b1;
                        else if (step != 0 && w >= step)
                            w = w - $urandom_range(0, step);
                    end
                    add_cmd(OP_CHECK, $urandom);
                    add_cmd(OP_COUNT, w);
                end
                3, 4:
                begin
                    n = $urandom_range(1, DEPTH + 2);
                    repeat (n) add_cmd(($urandom_range(0, 2) == 0) ? OP_PEEK : OP_DEQ, $urandom);
                end
                5, 6, 7:
                begin
                    n = $urandom_range(1, 12);
                    repeat (n) add_cmd(OPCODE_BITS'($urandom_range(0, 5)), pick_word());
                end
                8:
                begin
                    case ($urandom_range(0, 2))
                        0: add_cmd(OP_SPARE_6, $urandom);
                        1: add_cmd(OP_SPARE_7, $urandom);
                        default: add_cmd(OP_CLEAR, $urandom);
                    endcase
                end
                default:
                begin
                    // Alternate enqueue and dequeue so entries keep shifting toward the front cell.
                    n = $urandom_range(4, 2 * DEPTH);
                    repeat (n)
                    begin
                        add_cmd(OP_ENQ, pick_word());
                        add_cmd(OP_DEQ, $urandom);
                    end
                end
            endcase
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### fifo_queue_with_match_count_core.f
hw/rtl/fq_pkg.sv
hw/rtl/fq_cell.sv
hw/rtl/fq_ctrl.sv
hw/rtl/fifo_queue_with_match_count_core.sv
tb/sv/tb.sv
